// ===== sv/ffxd_pkg.sv =====
package ffxd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned WordW    = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned PosW     = 4;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned OutDataW = ByteW + 2 * WordW;

  localparam logic [PosW-1:0] XorIndex     = 4'd10;
  localparam logic [PosW-1:0] TypeIndex    = 4'd1;
  localparam logic [PosW-1:0] PayloadFirst = 4'd2;

  localparam logic [CfgAddrW-1:0] RegHeader   = 2'd0;
  localparam logic [CfgAddrW-1:0] RegTail     = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTypeMask = 2'd2;

  localparam logic [ByteW-1:0] HeaderReset   = 8'hAA;
  localparam logic [ByteW-1:0] TailReset     = 8'h55;
  localparam logic [ByteW-1:0] TypeMaskReset = 8'h7F;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StBadTail = 2'd1;
  localparam logic [StatusW-1:0] StBadXor  = 2'd2;
  localparam logic [StatusW-1:0] StBadType = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] payload_high;
    logic [WordW-1:0] payload_low;
    logic [ByteW-1:0] frame_type;
  } out_data_t;

endpackage

// ===== sv/fixed_frame_xor_deframer_unit.sv =====
// Fixed-length frame deframer with an XOR check byte.
// The in_ channel carries one received byte per beat. While hunting, the
// block waits for the header byte; it then collects FRAME_LENGTH bytes:
// type at index 1, eight payload bytes at indices 2 to 9, XOR of bytes
// 0 to 9 at index 10, and the tail byte in the last position.
// After the last byte one beat leaves on the out_ channel with the type and
// payload in out_tdata and the status in out_tuser (0 ok, 1 bad tail,
// 2 bad XOR, 3 type not enabled). Other bytes give no out_ beat.
// The last frame byte passes the input register, then the result register,
// before out_tvalid rises. One byte is taken every cycle while the receiver
// keeps up; the input and result registers form a two-stage pipe.
// When the receiver stalls, the result register holds its beat and the
// input register one byte; in_tready drops only when both are full, and
// during reset. Reset (rst_n low, synchronous) restores the registers to
// 0xAA, 0x55 and 0x7F, empties the pipe and returns to hunting.
// The cfg_ port writes register cfg_addr at each clock with cfg_we high;
// index 0 header, 1 tail, 2 type enable mask, others are ignored.
module fixed_frame_xor_deframer_unit #(
  parameter int unsigned FRAME_LENGTH = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffxd_pkg::ByteW-1:0]          in_tdata,   // rx_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // frame_type [7:0], payload_low [39:8], payload_high [71:40]
  output logic [ffxd_pkg::OutDataW-1:0]       out_tdata,
  output logic [ffxd_pkg::StatusW-1:0]        out_tuser,  // frame_status
  input  logic                                cfg_we,
  input  logic [ffxd_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [ffxd_pkg::ByteW-1:0]          cfg_wdata
);

  localparam logic [ffxd_pkg::PosW-1:0] LastPos = ffxd_pkg::PosW'(FRAME_LENGTH - 1);

  logic [ffxd_pkg::ByteW-1:0]    header_r, tail_r, mask_r;
  logic                          s1_valid_r;
  logic [ffxd_pkg::ByteW-1:0]    s1_byte_r;
  logic                          in_frame_r, in_frame_nxt;
  logic [ffxd_pkg::PosW-1:0]     pos_r, pos_nxt;
  logic [ffxd_pkg::ByteW-1:0]    xor_r, xor_nxt;
  logic                          xor_ok_r, xor_ok_nxt;
  logic [ffxd_pkg::ByteW-1:0]    type_r, type_nxt;
  logic [ffxd_pkg::PayloadW-1:0] payload_r, payload_nxt;
  logic                          out_valid_r;
  ffxd_pkg::out_data_t           out_data_r, out_data_nxt;
  logic [ffxd_pkg::StatusW-1:0]  out_status_r, status_nxt;
  logic                          out_free, s1_go, in_take, frame_done;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = rst_n && (!s1_valid_r || out_free);
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= ffxd_pkg::HeaderReset;
      tail_r   <= ffxd_pkg::TailReset;
      mask_r   <= ffxd_pkg::TypeMaskReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        ffxd_pkg::RegHeader:   header_r <= cfg_wdata;
        ffxd_pkg::RegTail:     tail_r   <= cfg_wdata;
        ffxd_pkg::RegTypeMask: mask_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    xor_nxt      = xor_r;
    xor_ok_nxt   = xor_ok_r;
    type_nxt     = type_r;
    payload_nxt  = payload_r;
    frame_done   = 1'b0;
    status_nxt   = ffxd_pkg::StOk;
    out_data_nxt = '{payload_high: payload_r[63:32], payload_low: payload_r[31:0],
                     frame_type: type_r};
    if (!in_frame_r) begin
      if (s1_byte_r == header_r) begin
        in_frame_nxt = 1'b1;
        pos_nxt      = ffxd_pkg::TypeIndex;
        xor_nxt      = s1_byte_r;
        xor_ok_nxt   = 1'b0;
      end
    end else begin
      if (pos_r == ffxd_pkg::TypeIndex) begin
        type_nxt = s1_byte_r;
      end
      for (int k = 0; k < 8; k++) begin
        if (pos_r == ffxd_pkg::PayloadFirst + ffxd_pkg::PosW'(k)) begin
          payload_nxt[8*k +: 8] = s1_byte_r;
        end
      end
      if (pos_r < ffxd_pkg::XorIndex) begin
        xor_nxt = xor_r ^ s1_byte_r;
      end
      if (pos_r == ffxd_pkg::XorIndex) begin
        xor_ok_nxt = (s1_byte_r == xor_r);
      end
      if (pos_r >= LastPos) begin
        frame_done   = 1'b1;
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
        if (s1_byte_r != tail_r) begin
          status_nxt = ffxd_pkg::StBadTail;
        end else if (!xor_ok_r) begin
          status_nxt = ffxd_pkg::StBadXor;
        end else if ((type_r[7:3] != '0) || !mask_r[type_r[2:0]]) begin
          status_nxt = ffxd_pkg::StBadType;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      in_frame_r  <= 1'b0;
      pos_r       <= '0;
      xor_r       <= '0;
      xor_ok_r    <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        in_frame_r  <= in_frame_nxt;
        pos_r       <= pos_nxt;
        xor_r       <= xor_nxt;
        xor_ok_r    <= xor_ok_nxt;
        out_valid_r <= frame_done;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_go) begin
      type_r    <= type_nxt;
      payload_r <= payload_nxt;
      if (frame_done) begin
        out_data_r   <= out_data_nxt;
        out_status_r <= status_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== sv/ffxd_checker.sv =====
module ffxd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ffxd_pkg::OutDataW-1:0]     out_tdata,
  input logic [ffxd_pkg::StatusW-1:0]      out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Stalled output beat changed.");

  a_ok_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ffxd_pkg::StOk) |-> (out_tdata[7:3] == '0))
    else $error("Frame reported ok with a type of eight or more.");

  a_rise_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("Output beat without an input beat two cycles earlier.");

  a_ready_reset: assert property (@(posedge clk)
    !rst_n |-> !in_tready)
    else $error("Input ready during reset.");

endmodule

bind fixed_frame_xor_deframer_unit ffxd_checker u_ffxd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb.sv =====
module tb;

  localparam int FrameLen    = 12;
  localparam int LimitCycles = 200000;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 116;

  localparam logic [ffxd_pkg::CfgAddrW-1:0] RegSpare = 2'd3;

  typedef logic [ffxd_pkg::ByteW-1:0] byte_t;

  typedef struct packed {
    logic [ffxd_pkg::StatusW-1:0] status;
    ffxd_pkg::out_data_t          data;
  } frame_result_t;

  class frame_checker;
    int                            frame_len;
    byte_t                         header_reg;
    byte_t                         tail_reg;
    byte_t                         mask_reg;
    bit                            in_frame;
    logic [ffxd_pkg::PosW-1:0]     pos;
    byte_t                         run_xor;
    bit                            xor_ok;
    byte_t                         held_type;
    logic [ffxd_pkg::PayloadW-1:0] held_payload;
    frame_result_t                 expected_frames[$];
    int                            mismatches;

    function new(int len);
      frame_len    = len;
      header_reg   = ffxd_pkg::HeaderReset;
      tail_reg     = ffxd_pkg::TailReset;
      mask_reg     = ffxd_pkg::TypeMaskReset;
      in_frame     = 1'b0;
      pos          = '0;
      run_xor      = '0;
      xor_ok       = 1'b0;
      held_type    = '0;
      held_payload = '0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [ffxd_pkg::CfgAddrW-1:0] idx, byte_t value);
      case (idx)
        ffxd_pkg::RegHeader:   header_reg = value;
        ffxd_pkg::RegTail:     tail_reg = value;
        ffxd_pkg::RegTypeMask: mask_reg = value;
        default: ;
      endcase
    endfunction

    // Returns 1 when the byte belongs to a frame, 0 when it is skipped while hunting.
    function bit note_byte(byte_t b);
      frame_result_t r;
      int            slot;
      if (!in_frame) begin
        if (b == header_reg) begin
          in_frame     = 1'b1;
          pos          = 4'd1;
          run_xor      = b;
          xor_ok       = 1'b0;
          held_type    = '0;
          held_payload = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      if (pos == ffxd_pkg::TypeIndex) held_type = b;
      if (pos >= ffxd_pkg::PayloadFirst && pos < ffxd_pkg::XorIndex) begin
        slot = int'(pos) - int'(ffxd_pkg::PayloadFirst);
        held_payload[slot*8 +: 8] = b;
      end
      if (pos < ffxd_pkg::XorIndex) run_xor = run_xor ^ b;
      if (pos == ffxd_pkg::XorIndex) xor_ok = (b == run_xor);
      if (int'(pos) >= frame_len - 1) begin
        if (b != tail_reg) r.status = ffxd_pkg::StBadTail;
        else if (!xor_ok) r.status = ffxd_pkg::StBadXor;
        else if (held_type > 8'd7 || !mask_reg[held_type[2:0]]) r.status = ffxd_pkg::StBadType;
        else r.status = ffxd_pkg::StOk;
        r.data.frame_type   = held_type;
        r.data.payload_low  = held_payload[31:0];
        r.data.payload_high = held_payload[63:32];
        expected_frames.push_back(r);
        in_frame = 1'b0;
        pos      = '0;
      end else begin
        pos = pos + 4'd1;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void check_frame(logic [ffxd_pkg::StatusW-1:0] st, ffxd_pkg::out_data_t d);
      frame_result_t e;
      if (expected_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected out beat, status %0d data %h", $time, st, d);
        return;
      end
      e = expected_frames.pop_front();
      if (e.status !== st) begin
        mismatches++;
        $display("%0t: frame_status expected %0d actual %0d", $time, e.status, st);
      end
      if (e.data.frame_type !== d.frame_type) begin
        mismatches++;
        $display("%0t: frame_type expected %h actual %h", $time, e.data.frame_type,
                 d.frame_type);
      end
      if (e.data.payload_low !== d.payload_low) begin
        mismatches++;
        $display("%0t: payload_low expected %h actual %h", $time, e.data.payload_low,
                 d.payload_low);
      end
      if (e.data.payload_high !== d.payload_high) begin
        mismatches++;
        $display("%0t: payload_high expected %h actual %h", $time, e.data.payload_high,
                 d.payload_high);
      end
    endfunction
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  byte_t                          in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ffxd_pkg::OutDataW-1:0]  out_tdata;
  logic [ffxd_pkg::StatusW-1:0]   out_tuser;
  logic                           cfg_we     = 1'b0;
  logic [ffxd_pkg::CfgAddrW-1:0]  cfg_addr   = '0;
  byte_t                          cfg_wdata  = '0;

  frame_checker sb;
  int           burst_left  = 0;
  int           frame_bytes = 0;
  int           ready_left  = 0;
  int           stall_left  = 0;
  int           cycle_count = 0;
  bit           paused      = 1'b0;

  fixed_frame_xor_deframer_unit #(
    .FRAME_LENGTH(FrameLen)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        ready_left = $urandom_range(40, 120);
        stall_left = 0;
      end else begin
        ready_left = $urandom_range(0, 6);
        stall_left = $urandom_range(1, 12);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_frame(out_tuser, ffxd_pkg::out_data_t'(out_tdata));
    end
  end

  task automatic push_byte(input byte_t b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (sb.note_byte(b)) frame_bytes++;
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [ffxd_pkg::CfgAddrW-1:0] idx, input byte_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic program_regs(input byte_t hdr, input byte_t tl, input byte_t mask);
    write_cfg(ffxd_pkg::RegHeader, hdr);
    write_cfg(ffxd_pkg::RegTail, tl);
    write_cfg(ffxd_pkg::RegTypeMask, mask);
    write_cfg(RegSpare, byte_t'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input byte_t ftype, input logic [ffxd_pkg::PayloadW-1:0] payload,
                            input byte_t xor_flip, input byte_t tl, input int len);
    byte_t fr [FrameLen];
    byte_t x;
    fr[0] = sb.header_reg;
    fr[ffxd_pkg::TypeIndex] = ftype;
    for (int k = 0; k < 8; k++) fr[int'(ffxd_pkg::PayloadFirst) + k] = payload[8*k +: 8];
    x = '0;
    for (int k = 0; k < int'(ffxd_pkg::XorIndex); k++) x = x ^ fr[k];
    fr[ffxd_pkg::XorIndex] = x ^ xor_flip;
    for (int k = int'(ffxd_pkg::XorIndex) + 1; k < FrameLen - 1; k++) fr[k] = byte_t'($urandom);
    fr[FrameLen-1] = tl;
    for (int k = 0; k < len; k++) push_byte(fr[k]);
  endtask

  task automatic send_random_frame();
    byte_t                         ftype;
    byte_t                         noise;
    byte_t                         flip;
    byte_t                         tl;
    logic [ffxd_pkg::PayloadW-1:0] payload;
    int                            len;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        noise = byte_t'($urandom);
        if (noise == sb.header_reg) noise = noise ^ 8'h01;
        push_byte(noise);
      end
    end
    if ($urandom_range(0, 9) < 7) ftype = byte_t'($urandom_range(0, 7));
    else ftype = byte_t'($urandom);
    payload = {$urandom, $urandom};
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(0, 7) == 0) payload[8*k +: 8] = sb.header_reg;
    end
    if ($urandom_range(0, 6) == 0) flip = byte_t'($urandom_range(1, 255));
    else flip = '0;
    if ($urandom_range(0, 6) == 0) tl = byte_t'($urandom);
    else tl = sb.tail_reg;
    len = ($urandom_range(0, 14) == 0) ? $urandom_range(1, FrameLen - 1) : FrameLen;
    send_frame(ftype, payload, flip, tl, len);
  endtask

  initial begin
    while (cycle_count < LimitCycles) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new(FrameLen);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes other than the header are skipped while hunting.
    push_byte(8'h00);
    push_byte(8'hFF);
    // Header and tail values inside the payload are plain data.
    send_frame(8'h00, 64'hFF00_AA55_0000_FFAA, 8'h00, ffxd_pkg::TailReset, FrameLen);
    // A type with no mask bit is reported as unknown.
    send_frame(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, ffxd_pkg::TailReset, FrameLen);
    wait_idle();

    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: program_regs(8'h00, 8'hFF, 8'hFF);
        2: program_regs(8'hFF, 8'h00, 8'h00);
        5: program_regs(ffxd_pkg::HeaderReset, ffxd_pkg::TailReset, ffxd_pkg::TypeMaskReset);
        default: program_regs(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
      endcase
      frame_bytes = 0;
      while (frame_bytes < PhaseItems) begin
        if (p == 3 && !paused && frame_bytes >= PhaseItems / 2) begin
          hold_until_drained();
          paused = 1'b1;
        end
        send_random_frame();
      end
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/ffxd_pkg.sv
sv/fixed_frame_xor_deframer_unit.sv
sv/ffxd_checker.sv
tb/tb.sv
